>>> design/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants of the scoped symbol table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int MAX_NEST    = 64;
    localparam int KEY_WIDTH   = 64;

    localparam int ADDR_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int NEST_W  = $clog2(MAX_NEST);
    localparam int DEPTH_W = $clog2(MAX_NEST + 1);

    typedef enum logic [2:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_ENTER   = 3'd2,
        CMD_EXIT    = 3'd3,
        CMD_DECLARE = 3'd4,
        CMD_LOOKUP  = 3'd5,
        CMD_SETTYPE = 3'd6,
        CMD_BOX     = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_SCOPES    = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_FUNCS     = 3'd3,
        ERR_NOFRAME   = 3'd4,
        ERR_TABLE     = 3'd5,
        ERR_LOCALS    = 3'd6,
        ERR_GLOBALS   = 3'd7
    } err_t;

    typedef struct packed {
        logic       boxed;
        logic       is_local;
        logic [7:0] slot;
        logic [6:0] depth;
        logic [3:0] etype;
    } attr_t;

    localparam int ATTR_W = $bits(attr_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAME,
        ST_SCAN,
        ST_CHECK,
        ST_WRITE,
        ST_OUT
    } state_t;

endpackage

>>> design/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// Generic simple dual-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> design/scoped_symbol_table.sv
// ----------------------------------------------------------------------------
// scoped_symbol_table
// Scoped symbol table engine: scopes, frames, declare, lookup and updates.
// ----------------------------------------------------------------------------
//  channel | dir | ports
//  s_      | in  | s_valid s_ready s_command s_name_key s_type_tag
//  m_      | out | m_valid m_ready m_found .. m_error_code
//
//  One transaction at a time. Scope and frame commands pass through ST_FRAME
//  and ST_OUT before m_valid rises. Declare, lookup, set type and mark boxed
//  scan the entry memory one entry per cycle in ST_SCAN, stopping at the first
//  hit, then go through ST_CHECK, ST_WRITE and ST_OUT; at most MAX_ENTRIES read.
//  The next command is accepted once the engine is idle and m_valid is low.
//  Reset needs no clearing pass; only written entries are ever read.
//  A stalled result holds in the output register until m_ready.
module scoped_symbol_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [63:0] s_name_key,
    input  logic [3:0]  s_type_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic        m_is_local,
    output logic [7:0]  m_slot_index,
    output logic [6:0]  m_frame_depth,
    output logic [3:0]  m_entry_type,
    output logic        m_boxed_flag,
    output logic [8:0]  m_max_locals,
    output logic [2:0]  m_error_code
);
    localparam int AW = sst_pkg::ADDR_W;
    localparam int CW = sst_pkg::CNT_W;
    localparam int NW = sst_pkg::NEST_W;
    localparam int DW = sst_pkg::DEPTH_W;
    localparam int KW = sst_pkg::KEY_WIDTH;

    sst_pkg::state_t state_reg, state_next;
    sst_pkg::cmd_t   cmd_reg;
    logic [KW-1:0]   key_reg;
    logic [3:0]      type_reg;

    logic [CW-1:0] live_reg, next_global_reg;
    logic [DW-1:0] sdepth_reg, fdepth_reg;
    logic [CW-1:0] scope_es [sst_pkg::MAX_NEST];
    logic [CW-1:0] scope_ls [sst_pkg::MAX_NEST];
    logic [CW-1:0] nl_reg [sst_pkg::MAX_NEST];
    logic [CW-1:0] pk_reg [sst_pkg::MAX_NEST];

    // registered read data of the scope and frame tables
    logic [CW-1:0] es_rd_reg, ls_rd_reg, nl_rd_reg, pk_rd_reg;

    // scan pointer and hit record
    logic [CW-1:0] ptr_reg;      // next entry index to present (counting down/up)
    logic [CW-1:0] lo_reg;       // scan lower bound
    logic          pend_reg;     // a read is in flight
    logic [AW-1:0] pidx_reg;     // index of read in flight
    logic          hit_reg;
    logic [AW-1:0] hidx_reg;
    sst_pkg::attr_t hattr_reg;

    // result register
    logic        o_valid_reg, o_found_reg;
    sst_pkg::attr_t o_attr_reg;
    logic [8:0]  o_max_reg;
    logic [2:0]  o_err_reg;

    // memory ports
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [KW-1:0] wkey, rkey;
    sst_pkg::attr_t wattr, rattr;
    logic [sst_pkg::ATTR_W-1:0] rattr_bits;

    sst_ram #(.DEPTH(sst_pkg::MAX_ENTRIES), .WIDTH(KW)) u_keys (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wkey),
        .raddr(raddr), .rdata(rkey));
    sst_ram #(.DEPTH(sst_pkg::MAX_ENTRIES), .WIDTH(sst_pkg::ATTR_W)) u_attrs (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wattr),
        .raddr(raddr), .rdata(rattr_bits));
    assign rattr = sst_pkg::attr_t'(rattr_bits);

    logic is_decl;
    assign is_decl = (cmd_reg == sst_pkg::CMD_DECLARE);
    logic [NW-1:0] fd1, sd1;
    assign fd1 = NW'(fdepth_reg - DW'(1));
    assign sd1 = NW'(sdepth_reg - DW'(1));
    logic scan_more;
    assign scan_more = is_decl ? (ptr_reg < live_reg) : (ptr_reg > lo_reg);
    logic [CW-1:0] ridx;
    assign ridx = is_decl ? ptr_reg : ptr_reg - CW'(1);
    assign raddr = ridx[AW-1:0];
    logic key_hit;
    assign key_hit = pend_reg && (rkey == key_reg);

    assign s_ready = (state_reg == sst_pkg::ST_IDLE) && !o_valid_reg;
    assign m_valid = o_valid_reg;
    assign m_found = o_found_reg;
    assign m_is_local = o_attr_reg.is_local;
    assign m_slot_index = o_attr_reg.slot;
    assign m_frame_depth = o_attr_reg.depth;
    assign m_entry_type = o_attr_reg.etype;
    assign m_boxed_flag = o_attr_reg.boxed;
    assign m_max_locals = o_max_reg;
    assign m_error_code = o_err_reg;

    // read the current scope and frame entries; the outermost scope starts at zero
    always_ff @(posedge aclk) begin
        es_rd_reg <= (sd1 == '0) ? '0 : scope_es[sd1];
        ls_rd_reg <= scope_ls[sd1];
        nl_rd_reg <= nl_reg[fd1];
        pk_rd_reg <= pk_reg[fd1];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sst_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (sst_pkg::cmd_t'(s_command) == sst_pkg::CMD_PUSH ||
                        sst_pkg::cmd_t'(s_command) == sst_pkg::CMD_POP ||
                        sst_pkg::cmd_t'(s_command) == sst_pkg::CMD_ENTER ||
                        sst_pkg::cmd_t'(s_command) == sst_pkg::CMD_EXIT) begin
                        state_next = sst_pkg::ST_FRAME;
                    end else begin
                        state_next = sst_pkg::ST_SCAN;
                    end
                end
            end
            sst_pkg::ST_FRAME: state_next = sst_pkg::ST_OUT;
            sst_pkg::ST_SCAN: begin
                if (key_hit || (!scan_more && !pend_reg)) begin
                    state_next = sst_pkg::ST_CHECK;
                end
            end
            sst_pkg::ST_CHECK: state_next = sst_pkg::ST_WRITE;
            sst_pkg::ST_WRITE: state_next = sst_pkg::ST_OUT;
            sst_pkg::ST_OUT: state_next = sst_pkg::ST_IDLE;
            default: state_next = sst_pkg::ST_IDLE;
        endcase
    end

    // declare allocation checks
    logic [CW-1:0] cur_nl;
    assign cur_nl = nl_rd_reg;
    logic          alloc_ok;
    sst_pkg::err_t alloc_err;
    always_comb begin
        alloc_ok = 1'b0;
        alloc_err = sst_pkg::ERR_OK;
        priority if (live_reg >= CW'(sst_pkg::MAX_ENTRIES)) begin
            alloc_err = sst_pkg::ERR_TABLE;
        end else if (fdepth_reg != '0 && cur_nl >= CW'(sst_pkg::MAX_ENTRIES)) begin
            alloc_err = sst_pkg::ERR_LOCALS;
        end else if (fdepth_reg == '0 &&
                     next_global_reg >= CW'(sst_pkg::MAX_ENTRIES)) begin
            alloc_err = sst_pkg::ERR_GLOBALS;
        end else begin
            alloc_ok = 1'b1;
        end
    end

    // write port: update hit entry or append new one
    sst_pkg::attr_t upd_attr, new_attr;
    always_comb begin
        upd_attr = hattr_reg;
        if (cmd_reg == sst_pkg::CMD_BOX) begin
            upd_attr.boxed = 1'b1;
        end else if (upd_attr.etype != type_reg) begin
            upd_attr.etype = 4'd0;
        end
        new_attr = '0;
        new_attr.etype = type_reg;
        new_attr.depth = 7'(fdepth_reg);
        new_attr.is_local = (fdepth_reg != '0);
        new_attr.slot = (fdepth_reg != '0) ? 8'(cur_nl) : 8'(next_global_reg);
        we = 1'b0;
        waddr = hidx_reg;
        wkey = key_reg;
        wattr = upd_attr;
        if (state_reg == sst_pkg::ST_WRITE) begin
            if (hit_reg) begin
                we = (cmd_reg != sst_pkg::CMD_LOOKUP);
            end else if (is_decl && alloc_ok) begin
                we = 1'b1;
                waddr = live_reg[AW-1:0];
                wattr = new_attr;
            end
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sst_pkg::ST_IDLE;
            live_reg <= '0;
            next_global_reg <= '0;
            sdepth_reg <= DW'(1);
            fdepth_reg <= '0;
            o_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (o_valid_reg && m_ready) begin
                o_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                sst_pkg::ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        cmd_reg <= sst_pkg::cmd_t'(s_command);
                        key_reg <= s_name_key[KW-1:0];
                        type_reg <= s_type_tag;
                        hit_reg <= 1'b0;
                        pend_reg <= 1'b0;
                        o_found_reg <= 1'b0;
                        o_attr_reg <= '0;
                        o_max_reg <= '0;
                        o_err_reg <= sst_pkg::ERR_OK;
                        if (sst_pkg::cmd_t'(s_command) == sst_pkg::CMD_DECLARE) begin
                            ptr_reg <= es_rd_reg;
                        end else begin
                            ptr_reg <= live_reg;
                            lo_reg <= '0;
                        end
                    end
                end
                sst_pkg::ST_FRAME: begin
                    unique case (cmd_reg)
                        sst_pkg::CMD_PUSH: begin
                            if (sdepth_reg >= DW'(sst_pkg::MAX_NEST)) begin
                                o_err_reg <= sst_pkg::ERR_SCOPES;
                            end else begin
                                scope_es[sdepth_reg[NW-1:0]] <= live_reg;
                                scope_ls[sdepth_reg[NW-1:0]] <=
                                    (fdepth_reg != '0) ? cur_nl : '0;
                                sdepth_reg <= sdepth_reg + DW'(1);
                            end
                        end
                        sst_pkg::CMD_POP: begin
                            if (sdepth_reg <= DW'(1)) begin
                                o_err_reg <= sst_pkg::ERR_UNDERFLOW;
                            end else begin
                                sdepth_reg <= sdepth_reg - DW'(1);
                                live_reg <= es_rd_reg;
                                if (fdepth_reg != '0) begin
                                    nl_reg[fd1] <= ls_rd_reg;
                                end
                            end
                        end
                        sst_pkg::CMD_ENTER: begin
                            if (fdepth_reg >= DW'(sst_pkg::MAX_NEST)) begin
                                o_err_reg <= sst_pkg::ERR_FUNCS;
                            end else begin
                                nl_reg[fdepth_reg[NW-1:0]] <= '0;
                                pk_reg[fdepth_reg[NW-1:0]] <= '0;
                                fdepth_reg <= fdepth_reg + DW'(1);
                            end
                        end
                        default: begin
                            if (fdepth_reg == '0) begin
                                o_err_reg <= sst_pkg::ERR_NOFRAME;
                            end else begin
                                fdepth_reg <= fdepth_reg - DW'(1);
                                o_max_reg <= 9'(pk_rd_reg);
                            end
                        end
                    endcase
                end
                sst_pkg::ST_SCAN: begin
                    if (key_hit) begin
                        hit_reg <= 1'b1;
                        hidx_reg <= pidx_reg;
                        hattr_reg <= rattr;
                        pend_reg <= 1'b0;
                    end else begin
                        pend_reg <= scan_more;
                        pidx_reg <= ridx[AW-1:0];
                        if (scan_more) begin
                            ptr_reg <= is_decl ? ptr_reg + CW'(1) : ptr_reg - CW'(1);
                        end
                    end
                end
                sst_pkg::ST_CHECK: begin
                end
                sst_pkg::ST_WRITE: begin
                    if (hit_reg) begin
                        o_found_reg <= 1'b1;
                        o_attr_reg <= (cmd_reg == sst_pkg::CMD_LOOKUP) ? hattr_reg
                                                                     : upd_attr;
                    end else if (is_decl) begin
                        if (!alloc_ok) begin
                            o_err_reg <= alloc_err;
                        end else begin
                            o_found_reg <= 1'b1;
                            o_attr_reg <= new_attr;
                            live_reg <= live_reg + CW'(1);
                            if (fdepth_reg != '0) begin
                                nl_reg[fd1] <= cur_nl + CW'(1);
                                if (cur_nl + CW'(1) > pk_rd_reg) begin
                                    pk_reg[fd1] <= cur_nl + CW'(1);
                                end
                            end else begin
                                next_global_reg <= next_global_reg + CW'(1);
                            end
                        end
                    end
                end
                sst_pkg::ST_OUT: o_valid_reg <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    // checks
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == sst_pkg::ST_IDLE) else $error("ready outside idle");
    a_out_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sst_pkg::ST_OUT |=> o_valid_reg) else $error("result lost");
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CW'(sst_pkg::MAX_ENTRIES)) else $error("live count overflow");
    a_err_nofound: assert property (@(posedge aclk) disable iff (!aresetn)
        o_valid_reg && o_err_reg != sst_pkg::ERR_OK |-> !o_found_reg)
        else $error("error with hit");
endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the scoped symbol table. Drives commands through a
// bursty valid/ready sender, mirrors the table in a behavioral predictor and
// compares every result transaction field by field against the prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic          found;
        logic          is_local;
        logic [7:0]    slot;
        logic [6:0]    depth;
        logic [3:0]    etype;
        logic          boxed;
        logic [8:0]    max_locals;
        sst_pkg::err_t err;
    } lookup_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_command = 3'd0;
    logic [63:0] s_name_key = 64'd0;
    logic [3:0]  s_type_tag = 4'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_found;
    logic        m_is_local;
    logic [7:0]  m_slot_index;
    logic [6:0]  m_frame_depth;
    logic [3:0]  m_entry_type;
    logic        m_boxed_flag;
    logic [8:0]  m_max_locals;
    logic [2:0]  m_error_code;

    scoped_symbol_table dut (.*);

    // Mirror of the table state
    logic [63:0]    sym_keys[sst_pkg::MAX_ENTRIES];
    sst_pkg::attr_t sym_attrs[sst_pkg::MAX_ENTRIES];
    int             live_cnt;
    int             scope_lvl;
    int             scope_entry_base[sst_pkg::MAX_NEST];
    int             scope_local_base[sst_pkg::MAX_NEST];
    int             global_next;
    int             frame_lvl;
    int             frame_next[sst_pkg::MAX_NEST];
    int             frame_peak[sst_pkg::MAX_NEST];

    lookup_result_t pending_results[$];
    int             fail_count = 0;
    int             burst_left = 0;
    logic [63:0]    key_pool[12];

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic lookup_result_t entry_view(sst_pkg::attr_t a);
        lookup_result_t r;
        r = '0;
        r.found    = 1'b1;
        r.is_local = a.is_local;
        r.slot     = a.slot;
        r.depth    = a.depth;
        r.etype    = a.etype;
        r.boxed    = a.boxed;
        return r;
    endfunction

    function automatic int innermost(logic [63:0] key);
        for (int i = live_cnt - 1; i >= 0; i--) begin
            if (sym_keys[i] == key) return i;
        end
        return -1;
    endfunction

    // Compute the result of one command and advance the mirror
    function automatic lookup_result_t predict_symbol(sst_pkg::cmd_t cmd,
                                                      logic [63:0] key,
                                                      logic [3:0] tag);
        lookup_result_t r;
        int             idx;
        int             slot;
        logic           loc;
        sst_pkg::attr_t a;
        r = '0;
        r.err = sst_pkg::ERR_OK;
        case (cmd)
            sst_pkg::CMD_PUSH: begin
                if (scope_lvl >= sst_pkg::MAX_NEST) r.err = sst_pkg::ERR_SCOPES;
                else begin
                    scope_entry_base[scope_lvl] = live_cnt;
                    scope_local_base[scope_lvl] = frame_lvl > 0 ? frame_next[frame_lvl-1] : 0;
                    scope_lvl++;
                end
            end
            sst_pkg::CMD_POP: begin
                if (scope_lvl <= 1) r.err = sst_pkg::ERR_UNDERFLOW;
                else begin
                    scope_lvl--;
                    live_cnt = scope_entry_base[scope_lvl];
                    if (frame_lvl > 0) frame_next[frame_lvl-1] = scope_local_base[scope_lvl];
                end
            end
            sst_pkg::CMD_ENTER: begin
                if (frame_lvl >= sst_pkg::MAX_NEST) r.err = sst_pkg::ERR_FUNCS;
                else begin
                    frame_next[frame_lvl] = 0;
                    frame_peak[frame_lvl] = 0;
                    frame_lvl++;
                end
            end
            sst_pkg::CMD_EXIT: begin
                if (frame_lvl == 0) r.err = sst_pkg::ERR_NOFRAME;
                else begin
                    frame_lvl--;
                    r.max_locals = 9'(frame_peak[frame_lvl]);
                end
            end
            sst_pkg::CMD_DECLARE: begin
                // Same name in the current scope: reuse and maybe widen
                for (int j = scope_entry_base[scope_lvl-1]; j < live_cnt; j++) begin
                    if (sym_keys[j] == key) begin
                        if (sym_attrs[j].etype != tag) sym_attrs[j].etype = 4'd0;
                        return entry_view(sym_attrs[j]);
                    end
                end
                if (live_cnt >= sst_pkg::MAX_ENTRIES) r.err = sst_pkg::ERR_TABLE;
                else if (frame_lvl > 0 && frame_next[frame_lvl-1] >= sst_pkg::MAX_ENTRIES)
                    r.err = sst_pkg::ERR_LOCALS;
                else if (frame_lvl == 0 && global_next >= sst_pkg::MAX_ENTRIES)
                    r.err = sst_pkg::ERR_GLOBALS;
                else begin
                    if (frame_lvl > 0) begin
                        slot = frame_next[frame_lvl-1];
                        frame_next[frame_lvl-1] = slot + 1;
                        if (frame_next[frame_lvl-1] > frame_peak[frame_lvl-1])
                            frame_peak[frame_lvl-1] = frame_next[frame_lvl-1];
                        loc = 1'b1;
                    end else begin
                        slot = global_next;
                        global_next = slot + 1;
                        loc = 1'b0;
                    end
                    a = '0;
                    a.etype    = tag;
                    a.depth    = frame_lvl[6:0];
                    a.slot     = slot[7:0];
                    a.is_local = loc;
                    sym_keys[live_cnt]  = key;
                    sym_attrs[live_cnt] = a;
                    live_cnt++;
                    r = entry_view(a);
                end
            end
            sst_pkg::CMD_LOOKUP: begin
                idx = innermost(key);
                if (idx >= 0) r = entry_view(sym_attrs[idx]);
            end
            sst_pkg::CMD_SETTYPE: begin
                idx = innermost(key);
                if (idx >= 0) begin
                    if (sym_attrs[idx].etype != tag) sym_attrs[idx].etype = 4'd0;
                    r = entry_view(sym_attrs[idx]);
                end
            end
            default: begin
                idx = innermost(key);
                if (idx >= 0) begin
                    sym_attrs[idx].boxed = 1'b1;
                    r = entry_view(sym_attrs[idx]);
                end
            end
        endcase
        return r;
    endfunction

    // Send one transaction; keep valid high inside a burst
    task automatic send_cmd(sst_pkg::cmd_t cmd, logic [63:0] key, logic [3:0] tag);
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_name_key <= key;
        s_type_tag <= tag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_symbol(cmd, key, tag));
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Drop valid and hold until every expected result has come
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver stall pattern: long ready stretches mixed with choppy phases
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge aclk);
            phase = (phase + 1) % 512;
            if (phase < 160) m_ready <= 1'b1;
            else if (phase < 320) m_ready <= ($urandom_range(0, 3) != 0);
            else m_ready <= ($urandom_range(0, 1) == 0);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        lookup_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (m_found !== e.found) begin
                    $error("found: expected %0d actual %0d", e.found, m_found); fail_count++;
                end
                if (m_is_local !== e.is_local) begin
                    $error("is_local: expected %0d actual %0d", e.is_local, m_is_local);
                    fail_count++;
                end
                if (m_slot_index !== e.slot) begin
                    $error("slot_index: expected %0d actual %0d", e.slot, m_slot_index);
                    fail_count++;
                end
                if (m_frame_depth !== e.depth) begin
                    $error("frame_depth: expected %0d actual %0d", e.depth, m_frame_depth);
                    fail_count++;
                end
                if (m_entry_type !== e.etype) begin
                    $error("entry_type: expected %0d actual %0d", e.etype, m_entry_type);
                    fail_count++;
                end
                if (m_boxed_flag !== e.boxed) begin
                    $error("boxed_flag: expected %0d actual %0d", e.boxed, m_boxed_flag);
                    fail_count++;
                end
                if (m_max_locals !== e.max_locals) begin
                    $error("max_locals: expected %0d actual %0d", e.max_locals, m_max_locals);
                    fail_count++;
                end
                if (m_error_code !== e.err) begin
                    $error("error_code: expected %0d actual %0d", e.err, m_error_code);
                    fail_count++;
                end
            end
        end
    end

    // Edge values, every command and the absent-entry cases
    task automatic test_basic;
        logic [63:0] ones;
        ones = '1;
        send_cmd(sst_pkg::CMD_POP, 64'd0, 4'd0);
        send_cmd(sst_pkg::CMD_EXIT, 64'd0, 4'd0);
        send_cmd(sst_pkg::CMD_LOOKUP, 64'd0, 4'd0);
        send_cmd(sst_pkg::CMD_DECLARE, ones, 4'hF);
        send_cmd(sst_pkg::CMD_DECLARE, 64'd0, 4'd0);
        send_cmd(sst_pkg::CMD_DECLARE, ones, 4'hF);
        send_cmd(sst_pkg::CMD_DECLARE, ones, 4'd3);
        send_cmd(sst_pkg::CMD_SETTYPE, 64'd0, 4'd5);
        send_cmd(sst_pkg::CMD_BOX, ones, 4'd0);
        send_cmd(sst_pkg::CMD_LOOKUP, ones, 4'd0);
        send_cmd(sst_pkg::CMD_SETTYPE, 64'h5A5A, 4'd1);
        send_cmd(sst_pkg::CMD_BOX, 64'h5A5A, 4'd0);
        // Scope pushed outside a frame, popped inside one
        send_cmd(sst_pkg::CMD_PUSH, 64'd0, 4'd0);
        send_cmd(sst_pkg::CMD_ENTER, 64'd0, 4'd0);
        send_cmd(sst_pkg::CMD_DECLARE, 64'hA5A5_A5A5_A5A5_A5A5, 4'd9);
        send_cmd(sst_pkg::CMD_DECLARE, ones, 4'd2);
        send_cmd(sst_pkg::CMD_LOOKUP, ones, 4'd0);
        send_cmd(sst_pkg::CMD_POP, 64'd0, 4'd0);
        send_cmd(sst_pkg::CMD_DECLARE, 64'h1, 4'd4);
        send_cmd(sst_pkg::CMD_EXIT, 64'd0, 4'd0);
        send_cmd(sst_pkg::CMD_LOOKUP, ones, 4'd0);
        drain();
    endtask

    // Scope nesting limit and underflow
    task automatic test_scope_limit;
        repeat (sst_pkg::MAX_NEST) send_cmd(sst_pkg::CMD_PUSH, 64'd0, 4'd0);
        repeat (sst_pkg::MAX_NEST) send_cmd(sst_pkg::CMD_POP, 64'd0, 4'd0);
        drain();
    endtask

    // Frame nesting limit and exit without a frame
    task automatic test_frame_limit;
        repeat (sst_pkg::MAX_NEST + 1) send_cmd(sst_pkg::CMD_ENTER, 64'd0, 4'd0);
        repeat (sst_pkg::MAX_NEST + 1) send_cmd(sst_pkg::CMD_EXIT, 64'd0, 4'd0);
        drain();
    endtask

    // Fill the table inside a frame until it reports full
    task automatic test_table_full;
        send_cmd(sst_pkg::CMD_ENTER, 64'd0, 4'd0);
        send_cmd(sst_pkg::CMD_PUSH, 64'd0, 4'd0);
        for (int i = 0; i < sst_pkg::MAX_ENTRIES; i++)
            send_cmd(sst_pkg::CMD_DECLARE, {$urandom, 24'd0, i[7:0]}, i[3:0]);
        send_cmd(sst_pkg::CMD_LOOKUP, key_pool[0], 4'd0);
        send_cmd(sst_pkg::CMD_POP, 64'd0, 4'd0);
        send_cmd(sst_pkg::CMD_EXIT, 64'd0, 4'd0);
        drain();
    endtask

    // Mostly well-formed nesting with random names and types
    task automatic test_random(int count);
        int            pick;
        sst_pkg::cmd_t cmd;
        logic [63:0]   key;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) drain();
            if ($urandom_range(0, 49) == 0)
                key_pool[$urandom_range(0, 11)] = {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            if (pick < 30) cmd = sst_pkg::CMD_DECLARE;
            else if (pick < 48) cmd = sst_pkg::CMD_LOOKUP;
            else if (pick < 56) cmd = sst_pkg::CMD_SETTYPE;
            else if (pick < 64) cmd = sst_pkg::CMD_BOX;
            else if (pick < 75) cmd = sst_pkg::CMD_PUSH;
            else if (pick < 86) cmd = sst_pkg::CMD_POP;
            else if (pick < 93) cmd = sst_pkg::CMD_ENTER;
            else cmd = sst_pkg::CMD_EXIT;
            key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                              : key_pool[$urandom_range(0, 11)];
            send_cmd(cmd, key, 4'($urandom_range(0, 15)));
        end
        drain();
    endtask

    // Run global slots out across repeated scopes
    task automatic test_globals_full;
        while (frame_lvl > 0) send_cmd(sst_pkg::CMD_EXIT, 64'd0, 4'd0);
        for (int s = 0; s < 3; s++) begin
            send_cmd(sst_pkg::CMD_PUSH, 64'd0, 4'd0);
            for (int i = 0; i < 100; i++)
                send_cmd(sst_pkg::CMD_DECLARE, {$urandom, 16'd0, s[7:0], i[7:0]}, 4'd1);
            send_cmd(sst_pkg::CMD_POP, 64'd0, 4'd0);
        end
        drain();
    endtask

    initial begin
        live_cnt    = 0;
        scope_lvl   = 1;
        global_next = 0;
        frame_lvl   = 0;
        for (int i = 0; i < sst_pkg::MAX_NEST; i++) begin
            scope_entry_base[i] = 0;
            scope_local_base[i] = 0;
            frame_next[i] = 0;
            frame_peak[i] = 0;
        end
        for (int i = 0; i < 12; i++) key_pool[i] = {$urandom, $urandom};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic();
        test_scope_limit();
        test_frame_limit();
        test_table_full();
        test_random(100);
        test_globals_full();
        repeat (300) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
